/* sv/lcsru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsru_pkg
// Shared types and constants for the LCS row update stream.
// ----------------------------------------------------------------------------
package lcsru_pkg;

  // Widths fixed by the field layout
  localparam int CODE_BITS  = 5;   // bits per pattern character
  localparam int SYM_W      = 5;   // text symbol code
  localparam int LEN_W      = 4;   // pattern length and LCS length
  localparam int IN_TDATA_W = 8;   // symbol padded to a whole byte
  localparam int CFG_IDX_W  = 1;   // two configuration registers

  typedef logic [SYM_W-1:0]     sym_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_PATTERN_CODES  = 1'd0;
  localparam cfg_idx_t CFG_PATTERN_LENGTH = 1'd1;

  // Reset value of the pattern length register
  localparam len_t LEN_RESET = 4'd1;

endpackage

/* sv/lcsru_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsru_cfg
// Configuration registers: pattern characters and pattern length.
// ----------------------------------------------------------------------------
module lcsru_cfg #(
  parameter int PATTERN_MAX = 10
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  lcsru_pkg::cfg_idx_t                          cfg_index,
  input  logic [lcsru_pkg::CODE_BITS*PATTERN_MAX-1:0]  cfg_data,
  output logic [lcsru_pkg::CODE_BITS*PATTERN_MAX-1:0]  pattern_codes,
  output lcsru_pkg::len_t                              pattern_length
);
  import lcsru_pkg::*;

  // Decode the index and update the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_codes  <= '0;
      pattern_length <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_CODES:  pattern_codes  <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/lcsru_row_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsru_row_core
// Combinational LCS row update: bit-parallel step with one carry chain.
// ----------------------------------------------------------------------------
module lcsru_row_core #(
  parameter int PATTERN_MAX   = 10,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic [PATTERN_MAX-1:0]                       row_prev,
  input  logic                                         start_req,
  input  lcsru_pkg::sym_t                              symbol,
  input  logic [lcsru_pkg::CODE_BITS*PATTERN_MAX-1:0]  pattern_codes,
  input  lcsru_pkg::len_t                              pattern_length,
  output logic [PATTERN_MAX-1:0]                       row_next,
  output lcsru_pkg::len_t                              lcs_length
);
  import lcsru_pkg::*;

  logic [PATTERN_MAX-1:0] len_mask;   // positions in use
  logic [PATTERN_MAX-1:0] match;      // pattern position equals symbol
  logic [PATTERN_MAX-1:0] row_eff;
  logic [PATTERN_MAX-1:0] flat;       // inverted row: set where the row stays level
  logic [PATTERN_MAX-1:0] carry_in;
  logic [PATTERN_MAX-1:0] flat_sum;
  logic [PATTERN_MAX-1:0] flat_next;
  sym_t                   code;
  len_t                   count;

  // Build the in-use mask and the match vector per position
  always_comb begin
    code = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      code        = pattern_codes[i*CODE_BITS +: CODE_BITS];
      len_mask[i] = (LEN_W'(i) < pattern_length);
      match[i]    = ({1'b0, code} < (CODE_BITS + 1)'(ALPHABET_SIZE)) && (code == symbol);
    end
  end

  // Clear the row on a start request; unused positions read as level
  assign row_eff  = start_req ? '0 : row_prev;
  assign flat     = ~row_eff | ~len_mask;
  assign carry_in = flat & match;

  // One add advances every run of level positions past its first match
  assign flat_sum  = flat + carry_in;
  assign flat_next = flat_sum | (flat & ~match);
  assign row_next  = ~flat_next & len_mask;

  // Count the rises to get the LCS length
  always_comb begin
    count = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      count = count + LEN_W'(row_next[i]);
    end
  end

  assign lcs_length = count;

endmodule

/* sv/lcs_row_update_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_row_update_stream
// Streaming longest-common-subsequence row update against a short pattern.
// ----------------------------------------------------------------------------
// The block takes one text symbol per clock cycle, unless the result stream
// stalls, and returns one result per symbol: the new difference-encoded DP
// row and the LCS length against the whole pattern. Each symbol passes an
// input register, then a result register; the rate is set by a single
// PATTERN_MAX-bit carry chain between those registers, which also closes the
// row feedback loop. Set tuser on a symbol to start a new text. Write the
// pattern registers only while no transfer is outstanding.
// ----------------------------------------------------------------------------
module lcs_row_update_stream #(
  parameter int PATTERN_MAX   = 10,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // Input stream
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [lcsru_pkg::IN_TDATA_W-1:0]             s_tdata,   // symbol[4:0], zero pad
  input  logic [0:0]                                   s_tuser,   // start_req
  // Result stream
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [((PATTERN_MAX + lcsru_pkg::LEN_W + 7) / 8) * 8 - 1:0]
                                                       m_tdata,   // row_mask, lcs_length, pad
  // Configuration write port
  input  logic                                         cfg_we,
  input  lcsru_pkg::cfg_idx_t                          cfg_index,
  input  logic [lcsru_pkg::CODE_BITS*PATTERN_MAX-1:0]  cfg_data
);
  import lcsru_pkg::*;

  localparam int OUT_W = $bits(m_tdata);

  logic [CODE_BITS*PATTERN_MAX-1:0] pattern_codes;
  len_t                             pattern_length;

  logic                   in_valid;
  sym_t                   in_symbol;
  logic                   in_start;
  logic [PATTERN_MAX-1:0] dp_row;
  logic [PATTERN_MAX-1:0] row_next;
  len_t                   len_next;
  logic [PATTERN_MAX-1:0] out_mask;
  len_t                   out_len;
  logic                   advance;

  lcsru_cfg #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pattern_codes  (pattern_codes),
    .pattern_length (pattern_length)
  );

  lcsru_row_core #(
    .PATTERN_MAX   (PATTERN_MAX),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_core (
    .row_prev       (dp_row),
    .start_req      (in_start),
    .symbol         (in_symbol),
    .pattern_codes  (pattern_codes),
    .pattern_length (pattern_length),
    .row_next       (row_next),
    .lcs_length     (len_next)
  );

  // Move the held symbol into the result register when that is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || !m_tvalid || m_tready;

  // Input register: take a transfer, drop it once it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_symbol <= s_tdata[SYM_W-1:0];
      in_start  <= s_tuser[0];
    end
  end

  // Stored row: advance with each processed symbol
  always_ff @(posedge clk) begin
    if (rst) begin
      dp_row <= '0;
    end else if (advance) begin
      dp_row <= row_next;
    end
  end

  // Result register: hold until the downstream transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mask <= row_next;
      out_len  <= len_next;
    end
  end

  assign m_tdata = OUT_W'({out_len, out_mask});

endmodule

/* sv/lcsru_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsru_checker
// Port-level checks for the LCS row update stream, bound to the top level.
// ----------------------------------------------------------------------------
module lcsru_checker #(
  parameter int PATTERN_MAX = 10,
  parameter int OUT_W       = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // Result must not change or vanish while stalled
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Length field is the popcount of the row mask
  a_len_popcount: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[PATTERN_MAX-1:0]) == m_tdata[PATTERN_MAX +: 4])
    else $error("lcs_length does not match row_mask");

  // Empty result register never stalls the input side
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lcs_row_update_stream lcsru_checker #(
  .PATTERN_MAX (PATTERN_MAX),
  .OUT_W       (OUT_W)
) u_lcsru_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* sim/lcs_row_update_stream_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_row_update_stream_tb
// Self-checking bench for the streaming LCS row update.
// ----------------------------------------------------------------------------
// Text symbols are streamed against a series of pattern settings. Each
// accepted symbol is run through a local row predictor that rebuilds the DP
// row from the stored difference mask. The predicted mask and LCS length are
// queued and compared with each result transfer in order. The sender works in
// random bursts and the receiver stalls in changing patterns. The pattern
// registers are rewritten only once the result stream has drained.
// ----------------------------------------------------------------------------
module lcs_row_update_stream_tb;
  import lcsru_pkg::*;

  localparam int ROW_W      = 10;    // pattern positions held in the row
  localparam int ALPHABET   = 26;    // codes below this are letters
  localparam int CODES_W    = CODE_BITS * ROW_W;
  localparam int IDLE_LIMIT = 3000;  // cycles without any transfer

  typedef struct packed {
    logic start;
    sym_t symbol;
  } text_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] mask;
    len_t             length;
  } row_result_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;    // symbol[4:0], zero pad
  logic [0:0]         s_tuser = '0;    // start_req
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;         // row_mask[9:0], lcs_length[13:10], pad
  logic               cfg_we = 1'b0;
  cfg_idx_t           cfg_index = CFG_PATTERN_CODES;
  logic [CODES_W-1:0] cfg_data = '0;

  // Local copy of the block's configuration and row
  logic [CODES_W-1:0] pat_codes = '0;
  len_t               pat_len = LEN_RESET;
  logic [ROW_W-1:0]   lcs_row = '0;

  text_item_t  text_q[$];
  row_result_t expected_rows[$];
  text_item_t  next_item;
  row_result_t exp_row;
  logic        in_fire = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  int          rx_span = 0;
  int          rx_tick = 0;
  int          idle_cycles = 0;
  int          err_count = 0;
  int          phase;

  lcs_row_update_stream uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Rebuild the row from prefix sums and take the max of left, above and diagonal
  function automatic logic [ROW_W-1:0] lcs_next_row(input logic [ROW_W-1:0] row,
                                                    input sym_t sym,
                                                    input logic [CODES_W-1:0] codes,
                                                    input len_t len);
    int n;
    int code;
    int v;
    int above[ROW_W+1];
    int cur[ROW_W+1];
    logic [ROW_W-1:0] mask;
    n = (len > ROW_W) ? ROW_W : int'(len);
    mask = '0;
    above[0] = 0;
    cur[0] = 0;
    for (int i = 0; i < n; i++) above[i+1] = above[i] + int'(row[i]);
    for (int i = 1; i <= n; i++) begin
      code = int'(codes[CODE_BITS*(i-1) +: CODE_BITS]);
      v = cur[i-1];
      if (code < ALPHABET && code == int'(sym) && above[i-1] + 1 > v) v = above[i-1] + 1;
      if (above[i] > v) v = above[i];
      cur[i] = v;
    end
    for (int i = 0; i < n; i++) if (cur[i+1] > cur[i]) mask[i] = 1'b1;
    return mask;
  endfunction

  // Pattern length: mostly in range, with zero and saturating values mixed in
  function automatic len_t pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return len_t'($urandom_range(1, ROW_W));
    else if (r < 16) return len_t'(ROW_W);
    else if (r == 16) return '0;
    else return len_t'($urandom_range(ROW_W + 1, 15));
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CODES_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    if (idx == CFG_PATTERN_CODES) pat_codes = value;
    else pat_len = value[LEN_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_symbol(input int sym, input logic start);
    text_q.push_back('{start: start, symbol: sym_t'(sym)});
  endtask

  // Wait until every symbol is sent and every result has come back
  task automatic drain_rows();
    while (text_q.size() != 0 || s_tvalid || expected_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Texts of random length, mostly over a narrow alphabet, with stray symbols
  task automatic queue_texts(input int count, input int alpha_hi);
    int left;
    int sym;
    logic start;
    left = 0;
    for (int k = 0; k < count; k++) begin
      start = 1'b0;
      if (left == 0) begin
        start = 1'b1;
        left = $urandom_range(1, 30);
      end else if ($urandom_range(0, 39) == 0) begin
        start = 1'b1;
      end
      left--;
      sym = ($urandom_range(0, 19) < 17) ? $urandom_range(0, alpha_hi) : $urandom_range(0, 31);
      add_symbol(sym, start);
    end
  endtask

  task automatic random_phase(input int n_items);
    int alpha_hi;
    int split;
    int r;
    logic [CODES_W-1:0] codes;
    alpha_hi = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 25);
    r = $urandom_range(0, 11);
    if (r == 0) begin
      codes = CODES_W'({$urandom, $urandom});
    end else if (r == 1) begin
      codes = ($urandom_range(0, 1) == 0) ? '0 : '1;
    end else begin
      for (int i = 0; i < ROW_W; i++)
        codes[CODE_BITS*i +: CODE_BITS] = ($urandom_range(0, 9) == 0) ?
          CODE_BITS'($urandom_range(ALPHABET, 31)) : CODE_BITS'($urandom_range(0, alpha_hi));
    end
    write_reg(CFG_PATTERN_CODES, codes);
    write_reg(CFG_PATTERN_LENGTH, CODES_W'(pick_length()));
    split = ($urandom_range(0, 2) == 0) ? n_items / 2 : n_items;
    queue_texts(split, alpha_hi);
    // Now and then drain and change the length before the second half of the texts
    if (split < n_items) begin
      drain_rows();
      write_reg(CFG_PATTERN_LENGTH, CODES_W'(pick_length()));
      queue_texts(n_items - split, alpha_hi);
    end
    drain_rows();
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0 || text_q.size() == 0) begin
        if (gap_left > 0) gap_left = gap_left - 1;
        s_tvalid <= 1'b0;
      end else begin
        next_item = text_q.pop_front();
        s_tdata <= {3'b000, next_item.symbol};
        s_tuser <= next_item.start;
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // Receiver: switch between free running, coin toss, sparse and cyclic stalls
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 200);
    end else begin
      rx_span = rx_span - 1;
    end
    rx_tick = rx_tick + 1;
    case (rx_mode)
      RX_FREE:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (rx_tick % 3 != 0);
    endcase
  end

  // Check results in order, then predict the row for each accepted symbol
  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rows.size() == 0) begin
        $error("result with nothing expected: m_tdata %h", m_tdata);
        err_count++;
      end else begin
        exp_row = expected_rows.pop_front();
        if (m_tdata[ROW_W-1:0] !== exp_row.mask) begin
          $error("row_mask expected %h actual %h", exp_row.mask, m_tdata[ROW_W-1:0]);
          err_count++;
        end
        if (m_tdata[ROW_W +: LEN_W] !== exp_row.length) begin
          $error("lcs_length expected %0d actual %0d", exp_row.length, m_tdata[ROW_W +: LEN_W]);
          err_count++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      if (s_tuser[0]) lcs_row = '0;
      lcs_row = lcs_next_row(lcs_row, s_tdata[SYM_W-1:0], pat_codes, pat_len);
      expected_rows.push_back('{mask: lcs_row, length: len_t'($countones(lcs_row))});
    end
  end

  // Watchdog: give up when nothing moves on either stream
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("lcs_row_update_stream_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Full-length pattern, letters and out-of-alphabet symbols
    write_reg(CFG_PATTERN_CODES, {5'd25, 5'd0, 5'd25, 5'd25, 5'd3,
                                  5'd1, 5'd0, 5'd2, 5'd1, 5'd0});
    write_reg(CFG_PATTERN_LENGTH, CODES_W'(ROW_W));
    add_symbol(0, 1'b1);
    add_symbol(1, 1'b0);
    add_symbol(2, 1'b0);
    add_symbol(25, 1'b0);
    add_symbol(26, 1'b0);
    add_symbol(31, 1'b0);
    add_symbol(0, 1'b0);
    add_symbol(3, 1'b0);
    add_symbol(25, 1'b1);
    add_symbol(0, 1'b0);
    drain_rows();

    // Pattern codes beyond the alphabet and a saturating length
    write_reg(CFG_PATTERN_CODES, {5'd0, 5'd1, 5'd25, 5'd25, 5'd0,
                                  5'd1, 5'd25, 5'd27, 5'd31, 5'd26});
    write_reg(CFG_PATTERN_LENGTH, CODES_W'(15));
    add_symbol(26, 1'b1);
    add_symbol(31, 1'b0);
    add_symbol(25, 1'b0);
    add_symbol(0, 1'b0);
    add_symbol(1, 1'b0);
    add_symbol(25, 1'b0);
    drain_rows();

    // Shorten mid-text so stored upper bits must be ignored
    write_reg(CFG_PATTERN_LENGTH, CODES_W'(3));
    add_symbol(0, 1'b0);
    add_symbol(1, 1'b0);
    add_symbol(25, 1'b0);
    drain_rows();

    // Empty pattern
    write_reg(CFG_PATTERN_LENGTH, '0);
    add_symbol(0, 1'b0);
    add_symbol(31, 1'b1);
    drain_rows();

    // All code bits set, single position
    write_reg(CFG_PATTERN_CODES, '1);
    write_reg(CFG_PATTERN_LENGTH, CODES_W'(1));
    add_symbol(31, 1'b0);
    add_symbol(0, 1'b0);
    drain_rows();

    for (phase = 0; phase < 11; phase++) random_phase(130);

    drain_rows();
    repeat (10) @(posedge clk);
    if (expected_rows.size() != 0) begin
      $error("%0d results never arrived", expected_rows.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("lcs_row_update_stream_tb: clean");
    end else begin
      $display("lcs_row_update_stream_tb: errors");
    end
    $finish;
  end

endmodule
